[rtl/jwf_pkg.sv]
// Shared constants and field widths for the joystick window filter.
`timescale 1ns / 1ps

package jwf_pkg;

    // window length default
    localparam int unsigned WINDOW_DEFAULT = 50;

    // input field widths
    localparam int unsigned X_RAW_W     = 8;
    localparam int unsigned Y_RAW_W     = 8;
    localparam int unsigned IR_W        = 12;
    localparam int unsigned S_TDATA_W   = 32;

    // result field widths
    localparam int unsigned X_POS_W     = 8;
    localparam int unsigned Y_AVG_W     = 9;
    localparam int unsigned IR_AVG_W    = 12;
    localparam int unsigned M_TDATA_W   = 32;

    // configuration
    localparam int unsigned CFG_W       = 12;
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 12'd2000;

    // joystick geometry
    localparam int unsigned CENTER      = 100;
    localparam int unsigned X_BREAK     = 50;
    localparam int unsigned X_FULL      = 100;
    localparam int unsigned AVG_MAX     = 155;   // largest centered joystick value
    localparam int unsigned IR_MAX      = 4095;

    // averaged joystick magnitude fits here for any window
    localparam int unsigned AVG_MAG_W   = 8;

    // t / 3 == (t * 171) >> 9, exact for t < 512
    localparam int unsigned THIRD_MUL   = 171;
    localparam int unsigned THIRD_SHIFT = 9;

endpackage

[rtl/jwf_lane.sv]
// One window lane: history memory with valid bits and a running sum.
`timescale 1ns / 1ps

module jwf_lane #(
    parameter int unsigned DEPTH = 50,
    parameter int unsigned DW    = 9,
    parameter int unsigned SW    = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic signed [DW-1:0] din,
    output logic signed [SW-1:0] sum
);
    import jwf_pkg::*;

    localparam int unsigned SLW = $clog2(DEPTH);

    logic signed [DW-1:0] mem [DEPTH];
    logic signed [DW-1:0] rd_reg;
    logic [DEPTH-1:0]     vld_reg;
    logic [SLW-1:0]       slot_reg, slot_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [DW-1:0] oldest;

    always_comb begin
        if (!en) begin
            slot_next = slot_reg;
        end else if (slot_reg == SLW'(DEPTH - 1)) begin
            slot_next = '0;
        end else begin
            slot_next = slot_reg + 1'b1;
        end
    end

    // read data always holds the entry at slot_reg
    assign oldest   = vld_reg[slot_reg] ? rd_reg : '0;
    assign sum_next = en ? (sum_reg + SW'(din) - SW'(oldest)) : sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mem[slot_reg] <= din;
        end
        rd_reg <= mem[slot_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            slot_reg <= '0;
            sum_reg  <= '0;
        end else begin
            if (en) begin
                vld_reg[slot_reg] <= 1'b1;
            end
            slot_reg <= slot_next;
            sum_reg  <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

[rtl/jwf_merge.sv]
// Merge stage: window division, piecewise x remap, IR threshold, output register.
`timescale 1ns / 1ps

module jwf_merge #(
    parameter int unsigned WINDOW = 50,
    parameter int unsigned XSW    = 14
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [XSW-1:0]             x_sum,
    input  logic signed [XSW-1:0]             y_sum,
    input  logic [jwf_pkg::IR_AVG_W-1:0]      ir_sum,
    input  logic [jwf_pkg::CFG_W-1:0]         ir_threshold,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // x_position[7:0], y_average[16:8], ir_average[28:17], ir_blocked[29], zeros
    output logic [jwf_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
    import jwf_pkg::*;

    localparam int unsigned MAGW = XSW - 1;
    localparam int unsigned KX   = MAGW + $clog2(WINDOW);
    localparam int unsigned MX   = ((1 << KX) + WINDOW - 1) / WINDOW;
    localparam int unsigned PW   = MAGW + KX;
    localparam logic [KX-1:0] MXV = KX'(MX);

    localparam logic signed [10:0] C_CENTER = 11'(CENTER);
    localparam logic signed [10:0] C_BREAK  = 11'(X_BREAK);
    localparam logic signed [10:0] C_FULL   = 11'(X_FULL);
    localparam logic [17:0]        C_THIRD  = 18'(THIRD_MUL);

    // ---- stage 2: magnitude times reciprocal ----
    logic            x_neg, y_neg;
    logic [MAGW-1:0] x_mag, y_mag;
    logic [PW-1:0]   x_prod, y_prod;
    logic            ready2, ready3;

    logic                   v2_reg;
    logic                   xneg_reg, yneg_reg;
    logic [AVG_MAG_W-1:0]   xmag_reg, ymag_reg;
    logic [IR_AVG_W-1:0]    ir_reg;
    logic                   blk_reg;

    assign x_neg  = x_sum[XSW-1];
    assign y_neg  = y_sum[XSW-1];
    assign x_mag  = x_neg ? MAGW'(-x_sum) : MAGW'(x_sum);
    assign y_mag  = y_neg ? MAGW'(-y_sum) : MAGW'(y_sum);
    assign x_prod = PW'(x_mag) * PW'(MXV);
    assign y_prod = PW'(y_mag) * PW'(MXV);

    assign ready3   = !m_axis_tvalid || m_axis_tready;
    assign ready2   = !v2_reg || ready3;
    assign in_ready = ready2;

    always_ff @(posedge aclk) begin
        if (ready2) begin
            xneg_reg <= x_neg;
            yneg_reg <= y_neg;
            xmag_reg <= AVG_MAG_W'(x_prod >> KX);
            ymag_reg <= AVG_MAG_W'(y_prod >> KX);
            ir_reg   <= ir_sum;
            blk_reg  <= (ir_sum < ir_threshold);
        end
    end

    // ---- stage 3: sign, remap, clamp ----
    logic signed [10:0] xa, ya;
    logic [8:0]         lo_t;
    logic [17:0]        lo_p;
    logic signed [10:0] lo_v, hi_v, xp;

    assign xa = xneg_reg ? -$signed({3'b000, xmag_reg}) : $signed({3'b000, xmag_reg});
    assign ya = yneg_reg ? -$signed({3'b000, ymag_reg}) : $signed({3'b000, ymag_reg});

    // lower piece: (a + 100) * 2 / 3 - 100, argument never negative
    assign lo_t = 9'((xa + C_CENTER) <<< 1);
    assign lo_p = 18'(lo_t) * C_THIRD;
    assign lo_v = $signed({2'b00, 9'(lo_p >> THIRD_SHIFT)}) - C_CENTER;
    // upper piece: (a - 50) * 2
    assign hi_v = (xa - C_BREAK) <<< 1;

    always_comb begin
        if (xa < C_BREAK) begin
            if (lo_v > 11'sd0) begin
                xp = 11'sd0;
            end else if (lo_v < -C_CENTER) begin
                xp = -C_CENTER;
            end else begin
                xp = lo_v;
            end
        end else begin
            if (hi_v > C_FULL) begin
                xp = C_FULL;
            end else if (hi_v < 11'sd0) begin
                xp = 11'sd0;
            end else begin
                xp = hi_v;
            end
        end
    end

    logic                 v3_reg;
    logic [X_POS_W-1:0]   xpos_reg;
    logic [Y_AVG_W-1:0]   yavg_reg;
    logic [IR_AVG_W-1:0]  iravg_reg;
    logic                 blk3_reg;

    always_ff @(posedge aclk) begin
        if (ready3) begin
            xpos_reg  <= X_POS_W'(xp);
            yavg_reg  <= Y_AVG_W'(ya);
            iravg_reg <= ir_reg;
            blk3_reg  <= blk_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready2) begin
                v2_reg <= in_valid;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = M_TDATA_W'({blk3_reg, iravg_reg, yavg_reg, xpos_reg});

endmodule

[rtl/joystick_window_filter_remap.sv]
// Top level: three window lanes, merge stage and the threshold register.
`timescale 1ns / 1ps

// Joystick and infrared window filter.
// Input stream s_axis_*: one transaction carries x_raw, y_raw and ir_sample.
// Result stream m_axis_*: one transaction per input, in order, with the
// remapped x position, averaged y, averaged IR and the beam-blocked flag.
// Config channel cfg_*: writes ir_threshold; always ready. Write it only
// while no transaction is in flight.
// Throughput: one transaction per cycle while the receiver is ready. The x, y
// and IR lanes each keep a WINDOW-entry history memory and a running sum
// updated with one add and one subtract in the accept cycle; the read port
// prefetches the oldest entry. A result passes the running sum, loaded at the
// accepting edge, then the reciprocal multiply register, then the remap and
// output register.
// Reset clears the running sums, slot pointers and per-entry valid bits, so
// all history reads as zero at once; no clearing pass. ir_threshold resets
// to 2000.
// When the receiver stalls, the pipeline fills its bubbles and then holds;
// s_axis_tready drops only when every stage is occupied.

module joystick_window_filter_remap #(
    parameter int unsigned WINDOW = jwf_pkg::WINDOW_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // x_raw[7:0], y_raw[15:8], ir_sample[27:16], zeros
    input  logic [jwf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // x_position[7:0], y_average[16:8], ir_average[28:17], ir_blocked[29], zeros
    output logic [jwf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [jwf_pkg::CFG_W-1:0]      cfg_data
);
    import jwf_pkg::*;

    localparam int unsigned XDW   = X_RAW_W + 1;
    localparam int unsigned XSW   = $clog2(AVG_MAX * WINDOW + 1) + 1;
    localparam int unsigned IRQW  = $clog2(IR_MAX / WINDOW + 1);
    localparam int unsigned IRDW  = IRQW + 1;
    localparam int unsigned IRSW  = IR_W + 1;
    localparam int unsigned KI    = IR_W + $clog2(WINDOW);
    localparam int unsigned MI    = ((1 << KI) + WINDOW - 1) / WINDOW;
    localparam int unsigned IPW   = IR_W + KI;
    localparam logic [KI-1:0] MIV = KI'(MI);

    logic [X_RAW_W-1:0] x_raw;
    logic [Y_RAW_W-1:0] y_raw;
    logic [IR_W-1:0]    ir_sample;

    assign x_raw     = s_axis_tdata[X_RAW_W-1:0];
    assign y_raw     = s_axis_tdata[X_RAW_W+Y_RAW_W-1:X_RAW_W];
    assign ir_sample = s_axis_tdata[X_RAW_W+Y_RAW_W+IR_W-1:X_RAW_W+Y_RAW_W];

    // threshold register
    logic [CFG_W-1:0] thr_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THRESHOLD_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // stage 1 handshake: lane sums are the stage 1 payload
    logic v1_reg, merge_ready, accept;

    assign s_axis_tready = !v1_reg || merge_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_axis_tready) begin
            v1_reg <= s_axis_tvalid;
        end
    end

    // lane inputs
    logic signed [XDW-1:0]  x_c, y_c;
    logic [IPW-1:0]         ir_prod;
    logic signed [IRDW-1:0] ir_q;

    assign x_c     = $signed(XDW'({1'b0, x_raw}) - XDW'(CENTER));
    assign y_c     = $signed(XDW'({1'b0, y_raw}) - XDW'(CENTER));
    assign ir_prod = IPW'(ir_sample) * IPW'(MIV);
    assign ir_q    = $signed({1'b0, IRQW'(ir_prod >> KI)});

    logic signed [XSW-1:0]  x_sum, y_sum;
    logic signed [IRSW-1:0] ir_sum;

    jwf_lane #(.DEPTH(WINDOW), .DW(XDW), .SW(XSW)) u_lane_x (
        .aclk(aclk), .aresetn(aresetn), .en(accept), .din(x_c), .sum(x_sum)
    );

    jwf_lane #(.DEPTH(WINDOW), .DW(XDW), .SW(XSW)) u_lane_y (
        .aclk(aclk), .aresetn(aresetn), .en(accept), .din(y_c), .sum(y_sum)
    );

    jwf_lane #(.DEPTH(WINDOW), .DW(IRDW), .SW(IRSW)) u_lane_ir (
        .aclk(aclk), .aresetn(aresetn), .en(accept), .din(ir_q), .sum(ir_sum)
    );

    jwf_merge #(.WINDOW(WINDOW), .XSW(XSW)) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (v1_reg),
        .in_ready      (merge_ready),
        .x_sum         (x_sum),
        .y_sum         (y_sum),
        .ir_sum        (ir_sum[IR_AVG_W-1:0]),
        .ir_threshold  (thr_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // running sums stay within what a full window of extreme samples gives
    a_x_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(x_sum) >= -int'(CENTER * WINDOW) && int'(x_sum) <= int'(AVG_MAX * WINDOW))
        else $error("x running sum out of range");

    a_ir_sum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !ir_sum[IRSW-1])
        else $error("ir running sum went negative or overflowed");

    // an accepted item never overwrites an unconsumed stage 1 sum
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && v1_reg |-> merge_ready)
        else $error("stage 1 overrun");

    // each accepted transaction reaches the merge stage on the next cycle
    a_stage1_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> v1_reg)
        else $error("accepted transaction lost before merge");

endmodule
